// File: rtl/conditional_execute_unit_top_macros.svh
// Assertion macros shared by the checker of the conditional execute unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CONDITIONAL_EXECUTE_UNIT_TOP_MACROS_SVH
`define CONDITIONAL_EXECUTE_UNIT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CXU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cxu assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CXU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cxu assertion failed");

`endif

// File: rtl/cxu_pkg.sv
// Types and constants of the conditional execute unit.
// Used by the front, the queue, the back module, the top level and the testbench.
package cxu_pkg;

  localparam logic [31:0] MEM_BASE_RESET = 32'h0000_0100;

  typedef enum logic [3:0] {
    OP_MOV = 4'd0,
    OP_MVN = 4'd1,
    OP_CMP = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_AND = 4'd5,
    OP_ORR = 4'd6,
    OP_EOR = 4'd7,
    OP_LSL = 4'd8,
    OP_LSR = 4'd9,
    OP_LDR = 4'd10,
    OP_STR = 4'd11,
    OP_BEQ = 4'd12
  } op_t;

  typedef enum logic [2:0] {
    CC_AL     = 3'd0,
    CC_GT     = 3'd1,
    CC_GE     = 3'd2,
    CC_LT     = 3'd3,
    CC_LE     = 3'd4,
    CC_EQ     = 3'd5,
    CC_NE     = 3'd6,
    CC_AL_ALT = 3'd7   // spare code, runs like always
  } cond_t;

  // Classified instruction as it travels from front to back.
  typedef struct packed {
    logic        op_valid;   // opcode names a real operation
    op_t         op;
    cond_t       cond;
    logic        set_flags;
    logic [3:0]  rd;
    logic [3:0]  rn;
    logic        use_imm;
    logic [3:0]  rm;
    logic [31:0] imm;
  } item_t;

  typedef struct packed {
    logic        reg_write;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic [3:0]  flags;
    logic        executed;
    logic        branch_taken;
    logic        address_fault;
  } res_t;

endpackage

// File: rtl/cxu_in_if.sv
// Input channel of the conditional execute unit: one decoded instruction per item.
// Depends on nothing but the field widths fixed in the block's definition.
interface cxu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [2:0]  condition;
  logic        set_flags;
  logic [3:0]  dest_reg;
  logic [3:0]  first_reg;
  logic        second_is_immediate;
  logic [3:0]  second_reg;
  logic [31:0] immediate;

  modport source (
    output valid, opcode, condition, set_flags, dest_reg, first_reg,
           second_is_immediate, second_reg, immediate,
    input  ready
  );
  modport sink (
    input  valid, opcode, condition, set_flags, dest_reg, first_reg,
           second_is_immediate, second_reg, immediate,
    output ready
  );
endinterface

// File: rtl/cxu_out_if.sv
// Result channel of the conditional execute unit: one result item per instruction.
// Depends on nothing but the field widths fixed in the block's definition.
interface cxu_out_if;
  logic        valid;
  logic        ready;
  logic        reg_write;
  logic [3:0]  reg_index;
  logic [31:0] reg_value;
  logic [3:0]  flags;
  logic        executed;
  logic        branch_taken;
  logic        address_fault;

  modport source (
    output valid, reg_write, reg_index, reg_value, flags, executed,
           branch_taken, address_fault,
    input  ready
  );
  modport sink (
    input  valid, reg_write, reg_index, reg_value, flags, executed,
           branch_taken, address_fault,
    output ready
  );
endinterface

// File: rtl/cxu_front.sv
// Front of the conditional execute unit: accepts items and classifies them.
// Depends on cxu_pkg and cxu_in_if.
module cxu_front
  import cxu_pkg::*;
(
  cxu_in_if.sink in_ch,
  input  logic   q_full,
  output logic   push,
  output item_t  push_item
);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_item           = '0;
    push_item.op_valid  = (in_ch.opcode <= OP_BEQ);
    push_item.op        = push_item.op_valid ? op_t'(in_ch.opcode) : OP_MOV;
    // condition code 7 runs like always
    push_item.cond      = (in_ch.condition == CC_AL_ALT) ? CC_AL : cond_t'(in_ch.condition);
    push_item.set_flags = in_ch.set_flags;
    push_item.rd        = in_ch.dest_reg;
    push_item.rn        = in_ch.first_reg;
    push_item.use_imm   = in_ch.second_is_immediate;
    push_item.rm        = in_ch.second_reg;
    push_item.imm       = in_ch.immediate;
  end

endmodule

// File: rtl/cxu_queue.sv
// Two-entry queue of classified items between the front and the back.
// Depends on cxu_pkg.
module cxu_queue
  import cxu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t      q_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;

  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);
  assign head  = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/cxu_back.sv
// Back of the conditional execute unit: register file, flags, data memory,
// execution of one item per cycle while results are taken, and the result register. Depends on cxu_pkg.
module cxu_back
  import cxu_pkg::*;
#(
  parameter int NUM_REGS  = 12,
  parameter int MEM_WORDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  item_t       head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);

  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic [31:0] rf_r [NUM_REGS];
  logic [3:0]  flags_r, flags_nxt;
  logic [31:0] mem_r [MEM_WORDS];
  logic        mem_vld_r [MEM_WORDS];
  logic [31:0] mem_base_r;
  logic        out_valid_r;
  res_t        out_r, res_nxt;

  logic [31:0] op_a, op_b, st_data, alu_val, diff, mem_off, mem_rd;
  logic [32:0] sum33;
  logic [29:0] mem_idx;
  logic [AW-1:0] mem_addr;
  logic        mem_fault, cond_ok, wr, st, n, z, v;
  logic [3:0]  add_flags, sub_flags;

  assign pop       = !empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // register reads: an index beyond the file reads zero
  always_comb begin
    op_a    = (5'(head.rn) < 5'(NUM_REGS)) ? rf_r[head.rn[RW-1:0]] : '0;
    st_data = (5'(head.rd) < 5'(NUM_REGS)) ? rf_r[head.rd[RW-1:0]] : '0;
    if (head.use_imm) begin
      op_b = head.imm;
    end else begin
      op_b = (5'(head.rm) < 5'(NUM_REGS)) ? rf_r[head.rm[RW-1:0]] : '0;
    end
  end

  always_comb begin
    n = flags_r[3];
    z = flags_r[2];
    v = flags_r[0];
    case (head.cond)
      CC_GT:   cond_ok = !z && (n == v);
      CC_GE:   cond_ok = (n == v);
      CC_LT:   cond_ok = (n != v);
      CC_LE:   cond_ok = z || (n != v);
      CC_EQ:   cond_ok = z;
      CC_NE:   cond_ok = !z;
      default: cond_ok = 1'b1;
    endcase
  end

  assign sum33 = {1'b0, op_a} + {1'b0, op_b};
  assign diff  = op_a - op_b;

  assign add_flags = {sum33[31], (sum33[31:0] == 32'd0), sum33[32],
                      (~(op_a[31] ^ op_b[31])) & (op_a[31] ^ sum33[31])};
  assign sub_flags = {diff[31], (diff == 32'd0), (op_a >= op_b),
                      (op_a[31] ^ op_b[31]) & (op_a[31] ^ diff[31])};

  // window check; the two low address bits drop out of the word index
  assign mem_off   = op_a - mem_base_r;
  assign mem_idx   = mem_off[31:2];
  assign mem_fault = (op_a < mem_base_r) || (mem_idx >= 30'(MEM_WORDS));
  assign mem_addr  = mem_idx[AW-1:0];
  assign mem_rd    = mem_vld_r[mem_addr] ? mem_r[mem_addr] : '0;

  always_comb begin
    case (head.op)
      OP_MOV:  alu_val = op_b;
      OP_MVN:  alu_val = ~op_b;
      OP_ADD:  alu_val = sum33[31:0];
      OP_SUB:  alu_val = diff;
      OP_AND:  alu_val = op_a & op_b;
      OP_ORR:  alu_val = op_a | op_b;
      OP_EOR:  alu_val = op_a ^ op_b;
      OP_LSL:  alu_val = (op_b >= 32'd32) ? '0 : (op_a << op_b[4:0]);
      OP_LSR:  alu_val = (op_b >= 32'd32) ? '0 : (op_a >> op_b[4:0]);
      OP_LDR:  alu_val = mem_rd;
      default: alu_val = '0;
    endcase
  end

  always_comb begin
    res_nxt   = '0;
    flags_nxt = flags_r;
    wr        = 1'b0;
    st        = 1'b0;
    if (!head.op_valid) begin
      res_nxt.executed = 1'b0;
    end else if (head.op == OP_CMP) begin
      flags_nxt        = sub_flags;
      res_nxt.executed = 1'b1;
    end else if (head.op == OP_BEQ) begin
      res_nxt.executed     = 1'b1;
      res_nxt.branch_taken = flags_r[2];
    end else if (cond_ok) begin
      res_nxt.executed = 1'b1;
      if (head.op == OP_LDR || head.op == OP_STR) begin
        if (mem_fault) begin
          res_nxt.address_fault = 1'b1;
          res_nxt.executed      = 1'b0;
        end else if (head.op == OP_LDR) begin
          wr = 1'b1;
        end else begin
          st = 1'b1;
        end
      end else begin
        wr = 1'b1;
        if (head.set_flags) begin
          case (head.op)
            OP_ADD:  flags_nxt = add_flags;
            OP_SUB:  flags_nxt = sub_flags;
            default: flags_nxt = {alu_val[31], (alu_val == 32'd0), flags_r[1:0]};
          endcase
        end
      end
    end
    // drop writes beyond the register file
    if (wr && (5'(head.rd) < 5'(NUM_REGS))) begin
      res_nxt.reg_write = 1'b1;
      res_nxt.reg_index = head.rd;
      res_nxt.reg_value = alu_val;
    end
    res_nxt.flags = flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      mem_base_r  <= MEM_BASE_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
      for (int i = 0; i < MEM_WORDS; i++) begin
        mem_vld_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        mem_base_r <= cfg_wr_data;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
        if (res_nxt.reg_write) begin
          rf_r[head.rd[RW-1:0]] <= alu_val;
        end
        if (st) begin
          mem_vld_r[mem_addr] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res_nxt;
      if (st) begin
        mem_r[mem_addr] <= st_data;
      end
    end
  end

endmodule

// File: rtl/conditional_execute_unit_top.sv
// Conditional execute unit, top level. Depends on cxu_pkg, cxu_in_if, cxu_out_if,
// cxu_front, cxu_queue and cxu_back.
//
// The unit executes one decoded ARM-style instruction per input item and returns
// exactly one result item for it. It sustains one item per clock while results are
// taken: the back stage reads the register file and flags and executes
// combinationally, and writes them back at the edge that pops the item, and that
// register and flag feedback loop is what sets the rate. An accepted item is written
// into a two-entry queue, executed from the queue head once the result register is
// free or being taken, and its result is captured in the result register, which
// drives the result port. The front keeps accepting while a result waits, until the
// queue fills. Reset clears the register file and flags at once; data memory words
// carry a valid bit each, so no clearing pass is needed and items are accepted right
// after reset. Write mem_base only while the unit is idle.
module conditional_execute_unit_top
  import cxu_pkg::*;
#(
  parameter int NUM_REGS  = 12,
  parameter int MEM_WORDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  cxu_in_if.sink      in_ch,
  cxu_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  item_t push_item, head;
  logic  push, pop, q_empty, q_full;
  res_t  res;

  // front: classify and push while the queue has room
  cxu_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // queue: decouple front and back stalls
  cxu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: execute and hold the result until taken
  cxu_back #(
    .NUM_REGS  (NUM_REGS),
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_res     (res)
  );

  // drive the result channel payload from the result register
  assign out_ch.reg_write     = res.reg_write;
  assign out_ch.reg_index     = res.reg_index;
  assign out_ch.reg_value     = res.reg_value;
  assign out_ch.flags         = res.flags;
  assign out_ch.executed      = res.executed;
  assign out_ch.branch_taken  = res.branch_taken;
  assign out_ch.address_fault = res.address_fault;

endmodule

// File: rtl/cxu_checker.sv
// Port-level checks for the conditional execute unit, bound to its top level.
// Depends on conditional_execute_unit_top_macros.svh.
`include "conditional_execute_unit_top_macros.svh"

module cxu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        reg_write,
  input logic [3:0]  reg_index,
  input logic [31:0] reg_value,
  input logic        executed,
  input logic        branch_taken,
  input logic        address_fault
);

  `CXU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CXU_ASSERT_IMP(a_no_write_zero, out_valid && !reg_write, reg_index == 4'd0 && reg_value == 32'd0)
  `CXU_ASSERT_IMP(a_fault_no_effect, out_valid && address_fault, !executed && !reg_write)
  `CXU_ASSERT_IMP(a_write_executed, out_valid && reg_write, executed && !branch_taken)
  `CXU_ASSERT_IMP(a_branch_executed, out_valid && branch_taken, executed && !address_fault)

endmodule

bind conditional_execute_unit_top cxu_checker u_cxu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .reg_write     (out_ch.reg_write),
  .reg_index     (out_ch.reg_index),
  .reg_value     (out_ch.reg_value),
  .executed      (out_ch.executed),
  .branch_taken  (out_ch.branch_taken),
  .address_fault (out_ch.address_fault)
);

// File: test/testbench.sv
// Self-checking testbench for conditional_execute_unit_top: drives decoded instructions,
// predicts every result item in-line and compares them field by field.
// Depends on cxu_pkg, cxu_in_if, cxu_out_if and the unit's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cxu_pkg::*;

  localparam int NUM_REGS      = 12;
  localparam int MEM_WORDS     = 8;
  localparam int HALF_PERIOD   = 6;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 8;     // idle wait once every result has drained
  localparam int PHASE_ITEMS   = 28;
  localparam int STALL_ITEMS   = 24;
  localparam int HOLD_CYCLES   = 60;

  // Opcodes past BEQ execute nothing.
  localparam logic [3:0] OPC_NOP_LO = 4'd13;
  localparam logic [3:0] OPC_NOP_HI = 4'd15;
  localparam bit USE_IMM = 1'b1;
  localparam bit USE_REG = 1'b0;

  // Idle settings per phase: none, sender gaps, receiver stalls, both.
  localparam int SEND_IDLE_SET [4] = '{0, 64, 0, 13};
  localparam int STALL_SET     [4] = '{0, 0, 64, 13};

  typedef struct {
    logic [3:0]  opcode;
    logic [2:0]  condition;
    logic        set_flags;
    logic [3:0]  dest_reg;
    logic [3:0]  first_reg;
    logic        use_imm;
    logic [3:0]  second_reg;
    logic [31:0] imm;
  } instr_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  cxu_in_if  in_ch();
  cxu_out_if out_ch();

  conditional_execute_unit_top #(
    .NUM_REGS (NUM_REGS),
    .MEM_WORDS(MEM_WORDS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Architectural state as the predictor sees it.
  logic [31:0] reg_file [NUM_REGS];
  logic [31:0] mem_words [MEM_WORDS];
  logic [3:0]  nzcv;
  logic [31:0] window_base;

  // Results of accepted instructions, oldest first.
  res_t pending_results [$];

  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int items_sent;
  int fail_count;
  int cycle_count;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: hold off for a counted stretch when asked, otherwise stall at random.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Indexes past the register file read as zero.
  function automatic logic [31:0] read_reg(logic [3:0] idx);
    return (idx < NUM_REGS) ? reg_file[idx] : 32'h0;
  endfunction

  function automatic bit cond_holds(logic [2:0] cc);
    logic n, z, v;
    n = nzcv[3];
    z = nzcv[2];
    v = nzcv[0];
    case (cc)
      CC_GT:   return !z && (n == v);
      CC_GE:   return n == v;
      CC_LT:   return n != v;
      CC_LE:   return z || (n != v);
      CC_EQ:   return z;
      CC_NE:   return !z;
      default: return 1'b1;
    endcase
  endfunction

  // Full NZCV from an add or a subtract; C on subtract means no borrow.
  function automatic logic [3:0] arith_flags(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] r, bit is_sub);
    logic c, v;
    if (is_sub) begin
      c = (a >= b);
      v = (a[31] ^ b[31]) & (a[31] ^ r[31]);
    end else begin
      c = (r < a);
      v = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
    end
    return {r[31], r == 32'h0, c, v};
  endfunction

  // Execute one instruction on the shadow state and return its result item.
  function automatic res_t execute_instr(instr_t it);
    res_t        r;
    logic [31:0] a, b, val, offs;
    bit          wr;
    int          idx;
    r   = '0;
    wr  = 1'b0;
    val = 32'h0;
    a   = read_reg(it.first_reg);
    b   = it.use_imm ? it.imm : read_reg(it.second_reg);
    if (it.opcode == OP_CMP) begin
      // compare ignores its condition and always sets all four flags
      nzcv       = arith_flags(a, b, a - b, 1'b1);
      r.executed = 1'b1;
    end else if (it.opcode == OP_BEQ) begin
      r.executed     = 1'b1;
      r.branch_taken = nzcv[2];
    end else if (it.opcode <= OP_STR && cond_holds(it.condition)) begin
      r.executed = 1'b1;
      case (it.opcode)
        OP_MOV:  val = b;
        OP_MVN:  val = ~b;
        OP_ADD:  val = a + b;
        OP_SUB:  val = a - b;
        OP_AND:  val = a & b;
        OP_ORR:  val = a | b;
        OP_EOR:  val = a ^ b;
        OP_LSL:  val = (b >= 32) ? 32'h0 : a << b[4:0];
        OP_LSR:  val = (b >= 32) ? 32'h0 : a >> b[4:0];
        default: val = 32'h0;
      endcase
      if (it.opcode == OP_LDR || it.opcode == OP_STR) begin
        offs = a - window_base;
        if (a < window_base || offs[31:2] >= MEM_WORDS) begin
          r.address_fault = 1'b1;
          r.executed      = 1'b0;
        end else begin
          idx = offs[31:2];
          if (it.opcode == OP_LDR) begin
            val = mem_words[idx];
            wr  = 1'b1;
          end else begin
            mem_words[idx] = read_reg(it.dest_reg);
          end
        end
      end else begin
        wr = 1'b1;
        if (it.set_flags) begin
          if (it.opcode == OP_ADD)      nzcv = arith_flags(a, b, val, 1'b0);
          else if (it.opcode == OP_SUB) nzcv = arith_flags(a, b, val, 1'b1);
          else                          nzcv = {val[31], val == 32'h0, nzcv[1:0]};
        end
      end
    end
    // writes to indexes past the register file are dropped
    if (wr && it.dest_reg < NUM_REGS) begin
      reg_file[it.dest_reg] = val;
      r.reg_write = 1'b1;
      r.reg_index = it.dest_reg;
      r.reg_value = val;
    end
    r.flags = nzcv;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Match each accepted result item against the oldest pending one.
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result item with no instruction pending");
      end else begin
        want = pending_results.pop_front();
        check_field("reg_write",     want.reg_write,     out_ch.reg_write);
        check_field("reg_index",     want.reg_index,     out_ch.reg_index);
        check_field("reg_value",     want.reg_value,     out_ch.reg_value);
        check_field("flags",         want.flags,         out_ch.flags);
        check_field("executed",      want.executed,      out_ch.executed);
        check_field("branch_taken",  want.branch_taken,  out_ch.branch_taken);
        check_field("address_fault", want.address_fault, out_ch.address_fault);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic instr_t mk(logic [3:0] op, logic [2:0] cc, bit s, logic [3:0] rd,
                                logic [3:0] rn, bit ui, logic [3:0] rm, logic [31:0] imm);
    instr_t it;
    it.opcode     = op;
    it.condition  = cc;
    it.set_flags  = s;
    it.dest_reg   = rd;
    it.first_reg  = rn;
    it.use_imm    = ui;
    it.second_reg = rm;
    it.imm        = imm;
    return it;
  endfunction

  // Mostly real registers, now and then any index, which may lie past the file.
  function automatic logic [3:0] pick_reg();
    return ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                    : 4'($urandom_range(NUM_REGS - 1));
  endfunction

  // Mix of shift-sized amounts, small values, extremes and full-width noise.
  function automatic logic [31:0] pick_imm();
    case ($urandom_range(4))
      0:       return $urandom_range(40);
      1:       return $urandom_range(255);
      2:       return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      3:       return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t random_instr();
    logic [3:0] op;
    if ($urandom_range(19) == 0) op = 4'($urandom_range(OPC_NOP_HI, OPC_NOP_LO));
    else                         op = 4'($urandom_range(int'(OP_BEQ)));
    return mk(op, 3'($urandom_range(7)), 1'($urandom_range(1)), pick_reg(), pick_reg(),
              1'($urandom_range(1)), pick_reg(), pick_imm());
  endfunction

  // Offer one item, idling first at random; record its result once accepted.
  // Leave valid high on return so a following item goes out back to back.
  task automatic send_instr(instr_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid               <= 1'b1;
    in_ch.opcode              <= it.opcode;
    in_ch.condition           <= it.condition;
    in_ch.set_flags           <= it.set_flags;
    in_ch.dest_reg            <= it.dest_reg;
    in_ch.first_reg           <= it.first_reg;
    in_ch.second_is_immediate <= it.use_imm;
    in_ch.second_reg          <= it.second_reg;
    in_ch.immediate           <= it.imm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.insert(pending_results.size(), execute_instr(it));
    items_sent++;
  endtask

  // Point a register into, just below or just past the window, then load and store through it.
  task automatic send_mem_burst();
    logic [3:0]  areg;
    logic [31:0] addr;
    logic [3:0]  op;
    areg = 4'($urandom_range(NUM_REGS - 1));
    if ($urandom_range(9) == 0) addr = window_base - 4;
    else addr = window_base + 4 * $urandom_range(MEM_WORDS) + $urandom_range(3);
    send_instr(mk(OP_MOV, CC_AL, 1'b0, areg, areg, USE_IMM, areg, addr));
    repeat ($urandom_range(4, 1)) begin
      op = ($urandom_range(1) != 0) ? OP_LDR : OP_STR;
      send_instr(mk(op, ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : CC_AL,
                    1'($urandom_range(1)), pick_reg(), areg, 1'($urandom_range(1)),
                    pick_reg(), pick_imm()));
    end
  endtask

  // Compare, then a few instructions that depend on the flags it left.
  task automatic send_flag_burst();
    instr_t it;
    send_instr(mk(OP_CMP, 3'($urandom_range(7)), 1'($urandom_range(1)), pick_reg(),
                  pick_reg(), 1'($urandom_range(1)), pick_reg(), pick_imm()));
    repeat ($urandom_range(3, 1)) begin
      it = random_instr();
      it.condition = 3'($urandom_range(CC_NE, CC_GT));
      send_instr(it);
    end
  endtask

  task automatic run_random_items(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: send_mem_burst();
        5, 6, 7:       send_flag_burst();
        default:       send_instr(random_instr());
      endcase
    end
  endtask

  // Drop valid, let every result drain, then write the register while idle.
  task automatic write_mem_base(logic [31:0] value);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    window_base = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk through every operation, every condition but LT, and corner cases in a fixed order.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_instr(mk(OP_MOV, CC_AL, 1'b1, 4'd0, 4'd0, USE_IMM, 4'd0, 32'hFFFF_FFFF));
    send_instr(mk(OP_MVN, CC_AL, 1'b1, 4'd1, 4'd0, USE_IMM, 4'd0, 32'hFFFF_FFFF));
    // branch ignores its condition and S, and is taken on Z
    send_instr(mk(OP_BEQ, CC_NE, 1'b1, 4'd0, 4'd0, USE_IMM, 4'd0, 32'h0));
    // carry out with a zero result
    send_instr(mk(OP_ADD, CC_EQ, 1'b1, 4'd2, 4'd0, USE_IMM, 4'd0, 32'h1));
    send_instr(mk(OP_MOV, CC_AL, 1'b0, 4'd3, 4'd0, USE_IMM, 4'd0, 32'h7FFF_FFFF));
    // signed overflow on add
    send_instr(mk(OP_ADD, CC_AL, 1'b1, 4'd4, 4'd3, USE_IMM, 4'd0, 32'h1));
    // borrow on subtract
    send_instr(mk(OP_SUB, CC_GE, 1'b1, 4'd5, 4'd1, USE_IMM, 4'd0, 32'h1));
    // compare with a failing condition still runs
    send_instr(mk(OP_CMP, CC_EQ, 1'b0, 4'd0, 4'd3, USE_REG, 4'd3, 32'h0));
    send_instr(mk(OP_BEQ, CC_AL, 1'b0, 4'd0, 4'd0, USE_IMM, 4'd0, 32'h0));
    // logical S keeps C and V
    send_instr(mk(OP_AND, CC_LE, 1'b1, 4'd6, 4'd0, USE_IMM, 4'd0, 32'h0F0F_0F0F));
    send_instr(mk(OP_ORR, CC_GT, 1'b1, 4'd7, 4'd5, USE_REG, 4'd3, 32'h0));
    send_instr(mk(OP_EOR, CC_AL_ALT, 1'b1, 4'd8, 4'd0, USE_REG, 4'd4, 32'h0));
    // shifts at 31, at 32 and by the widest amount
    send_instr(mk(OP_LSL, CC_AL, 1'b0, 4'd9, 4'd0, USE_IMM, 4'd0, 32'd31));
    send_instr(mk(OP_LSL, CC_AL, 1'b1, 4'd9, 4'd0, USE_IMM, 4'd0, 32'd32));
    send_instr(mk(OP_LSR, CC_AL, 1'b0, 4'd10, 4'd0, USE_IMM, 4'd0, 32'hFFFF_FFFF));
    // store and load through an address with its low bits set
    send_instr(mk(OP_MOV, CC_AL, 1'b0, 4'd11, 4'd0, USE_IMM, 4'd0, window_base + 3));
    send_instr(mk(OP_STR, CC_AL, 1'b1, 4'd3, 4'd11, USE_IMM, 4'd0, 32'h0));
    send_instr(mk(OP_LDR, CC_AL, 1'b1, 4'd2, 4'd11, USE_IMM, 4'd0, 32'h0));
    // faults just below and just past the window
    send_instr(mk(OP_MOV, CC_AL, 1'b0, 4'd11, 4'd0, USE_IMM, 4'd0, window_base - 4));
    send_instr(mk(OP_LDR, CC_AL, 1'b0, 4'd2, 4'd11, USE_IMM, 4'd0, 32'h0));
    send_instr(mk(OP_MOV, CC_AL, 1'b0, 4'd11, 4'd0, USE_IMM, 4'd0,
                  window_base + 4 * MEM_WORDS));
    send_instr(mk(OP_STR, CC_AL, 1'b0, 4'd3, 4'd11, USE_IMM, 4'd0, 32'h0));
    // registers past the file read as zero and drop writes
    send_instr(mk(OP_ADD, CC_AL, 1'b0, 4'd15, 4'd15, USE_REG, 4'd15, 32'h0));
    send_instr(mk(OPC_NOP_HI, CC_AL, 1'b1, 4'd0, 4'd0, USE_IMM, 4'd0, 32'h0));
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so the
  // unit fills up and pushes back on its input.
  task automatic test_input_stall();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = HOLD_CYCLES;
    repeat (STALL_ITEMS) send_instr(random_instr());
  endtask

  // Random traffic under several window bases, extremes included, each one
  // through every idle setting.
  task automatic test_window_settings();
    logic [31:0] bases [5];
    bases[0] = 32'h0;
    bases[1] = 32'hFFFF_FFFC;
    bases[2] = $urandom_range(32'hFFFF_FFFC) & 32'hFFFF_FFFC;
    bases[3] = $urandom_range(32'hFFFF_FFFC);
    bases[4] = MEM_BASE_RESET;
    foreach (bases[i]) begin
      write_mem_base(bases[i]);
      for (int p = 0; p < 4; p++) begin
        send_idle_pct = SEND_IDLE_SET[p];
        stall_pct     = STALL_SET[p];
        run_random_items(PHASE_ITEMS);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Hold every input at a known value while reset is held low.
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 32'h0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_MOV;
    in_ch.condition           = CC_AL;
    in_ch.set_flags           = 1'b0;
    in_ch.dest_reg            = 4'd0;
    in_ch.first_reg           = 4'd0;
    in_ch.second_is_immediate = 1'b0;
    in_ch.second_reg          = 4'd0;
    in_ch.immediate           = 32'h0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    items_sent    = 0;
    fail_count    = 0;
    cycle_count   = 0;
    reg_file      = '{default: 32'h0};
    mem_words     = '{default: 32'h0};
    nzcv          = 4'h0;
    window_base   = MEM_BASE_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_input_stall();
    test_window_settings();

    // Stop offering, drain every pending result, then let the unit settle before reporting the status.
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
